@@ hw/rtl/dwa_pkg.sv @@
// Shared types, constants and helper functions of the DFA word acceptor.
package dwa_pkg;

    localparam int STATE_W     = 6;
    localparam int SYM_W       = 8;
    localparam int ACCEPT_W    = 64;
    localparam int ENTRY_W     = STATE_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int QUEUE_DEPTH = 4;

    localparam int NUM_STATES_DEF  = 64;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 2'd1;

    typedef enum logic [1:0] {
        ACT_WR_TRANS = 2'd0,
        ACT_WR_ALPHA = 2'd1,
        ACT_SYMBOL   = 2'd2,
        ACT_EMPTY    = 2'd3
    } t_action;

    // OUT_ACCEPTED doubles as "no failure" in the running fail cause
    typedef enum logic [1:0] {
        OUT_ACCEPTED        = 2'd0,
        OUT_NOT_IN_ALPHABET = 2'd1,
        OUT_NO_TRANSITION   = 2'd2,
        OUT_NON_FINAL       = 2'd3
    } t_outcome;

    typedef enum logic [0:0] {
        BK_FETCH  = 1'b0,
        BK_LOOKUP = 1'b1
    } t_bk_state;

    typedef struct packed {
        t_action              op;
        logic [STATE_W-1:0]   from_state;
        logic [SYM_W-1:0]     symbol;
        logic                 sym_oob;
        logic [STATE_W-1:0]   to_state;
        logic                 entry_valid;
        logic                 last;
    } t_cmd;

    typedef struct packed {
        logic [STATE_W-1:0]  start_state;
        logic [ACCEPT_W-1:0] accept_mask;
    } t_cfg;

    typedef struct packed {
        logic               accepted;
        t_outcome           outcome;
        logic [STATE_W-1:0] end_state;
    } t_verdict;

    function automatic t_verdict make_verdict(
        input logic [STATE_W-1:0]  cur,
        input t_outcome            fail,
        input logic [ACCEPT_W-1:0] mask
    );
        t_verdict v;
        v.end_state = cur;
        if (fail != OUT_ACCEPTED) begin
            v.accepted = 1'b0;
            v.outcome  = fail;
        end else if (mask[cur]) begin
            v.accepted = 1'b1;
            v.outcome  = OUT_ACCEPTED;
        end else begin
            v.accepted = 1'b0;
            v.outcome  = OUT_NON_FINAL;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/dwa_if.sv @@
// Handshake channel interfaces: input items, verdicts and register writes.
interface dwa_in_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  action;
    logic [dwa_pkg::STATE_W-1:0] from_state;
    logic [dwa_pkg::SYM_W-1:0]   symbol;
    logic [dwa_pkg::STATE_W-1:0] to_state;
    logic                        entry_valid;
    logic                        last_symbol;

    modport source (output valid, action, from_state, symbol, to_state, entry_valid,
                    last_symbol, input ready);
    modport sink   (input valid, action, from_state, symbol, to_state, entry_valid,
                    last_symbol, output ready);
endinterface

interface dwa_out_if;
    logic                        valid;
    logic                        ready;
    logic                        accepted;
    logic [1:0]                  outcome;
    logic [dwa_pkg::STATE_W-1:0] end_state;

    modport source (output valid, accepted, outcome, end_state, input ready);
    modport sink   (input valid, accepted, outcome, end_state, output ready);
endinterface

interface dwa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dwa_pkg::CFG_IDX_W-1:0]  index;
    logic [dwa_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/dfa_word_acceptor.sv @@
// Top level of the DFA word acceptor: config registers, front end, queue, back end.
//
//  channel  | dir | transfer carries
//  ---------+-----+--------------------------------------------------------------
//  i_in     | in  | action, from_state, symbol, to_state, entry_valid, last_symbol
//  o_out    | out | accepted, outcome, end_state
//  i_cfg    | in  | index (0 start_state, 1 accept_mask), data
//
//  Word symbols need fetch and then lookup in the back end: the table RAM read is
//  registered and its address needs the state produced by the previous symbol. Loads
//  and empty-word items use fetch alone. After reset a sweep over all table entries
//  (NUM_STATES * 2**SYMBOL_BITS) clears both stores; i_in.ready stays low meanwhile,
//  while register writes are always taken. A 4-entry queue decouples the front end
//  from the back end; the verdict register lets the back end go on while o_out stalls.
module dfa_word_acceptor #(
    parameter int NUM_STATES  = dwa_pkg::NUM_STATES_DEF,
    parameter int SYMBOL_BITS = dwa_pkg::SYMBOL_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dwa_in_if.sink   i_in,
    dwa_out_if.source o_out,
    dwa_cfg_if.sink  i_cfg
);

    logic [dwa_pkg::STATE_W-1:0]  r_start_state;
    logic [dwa_pkg::ACCEPT_W-1:0] r_accept_mask;
    dwa_pkg::t_cfg                cfg;
    logic                         cfg_wr;

    logic          clr_busy;
    logic          q_full;
    logic          q_push;
    dwa_pkg::t_cmd q_push_data;
    logic          q_valid;
    dwa_pkg::t_cmd q_head;
    logic          q_pop;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_accept_mask <= '0;
        end else if (cfg_wr) begin
            priority if (i_cfg.index == dwa_pkg::CFG_START_STATE) begin
                r_start_state <= i_cfg.data[dwa_pkg::STATE_W-1:0];
            end else if (i_cfg.index == dwa_pkg::CFG_ACCEPT_MASK) begin
                r_accept_mask <= i_cfg.data[dwa_pkg::ACCEPT_W-1:0];
            end else begin
                r_start_state <= r_start_state;
            end
        end
    end

    always_comb begin
        cfg.start_state = r_start_state;
        cfg.accept_mask = r_accept_mask;
    end

    dwa_front #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_front (
        .i_in       (i_in),
        .i_clr_busy (clr_busy),
        .i_full     (q_full),
        .o_push     (q_push),
        .o_cmd      (q_push_data)
    );

    dwa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .o_valid     (q_valid),
        .o_head      (q_head),
        .i_pop       (q_pop)
    );

    dwa_back #(
        .NUM_STATES  (NUM_STATES),
        .SYMBOL_BITS (SYMBOL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_head_valid (q_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_clr_busy   (clr_busy),
        .o_out        (o_out)
    );

endmodule

@@ hw/rtl/dwa_ram.sv @@
// Generic simple dual-port RAM, one write port and one registered read port.
module dwa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/dwa_front.sv @@
// Front end: takes input items, range-checks and decodes them into commands.
module dwa_front #(
    parameter int NUM_STATES  = dwa_pkg::NUM_STATES_DEF,
    parameter int SYMBOL_BITS = dwa_pkg::SYMBOL_BITS_DEF
) (
    dwa_in_if.sink        i_in,
    input  logic          i_clr_busy,
    input  logic          i_full,
    output logic          o_push,
    output dwa_pkg::t_cmd o_cmd
);

    logic          rdy;
    logic          from_oob;
    logic          sym_oob;
    logic          drop;
    dwa_pkg::t_cmd cmd;

    assign rdy      = !i_full && !i_clr_busy;
    assign from_oob = 9'(i_in.from_state) >= 9'(NUM_STATES);
    assign sym_oob  = 9'(i_in.symbol) >= 9'(1 << SYMBOL_BITS);

    always_comb begin
        cmd.op          = dwa_pkg::t_action'(i_in.action);
        cmd.from_state  = i_in.from_state;
        cmd.symbol      = i_in.symbol;
        cmd.sym_oob     = sym_oob;
        cmd.to_state    = i_in.to_state;
        cmd.entry_valid = i_in.entry_valid;
        cmd.last        = i_in.last_symbol;
    end

    // loads that land outside the tables have no effect, never queue them
    always_comb begin
        unique case (cmd.op)
            dwa_pkg::ACT_WR_TRANS: drop = from_oob || sym_oob;
            dwa_pkg::ACT_WR_ALPHA: drop = sym_oob;
            dwa_pkg::ACT_SYMBOL:   drop = 1'b0;
            dwa_pkg::ACT_EMPTY:    drop = 1'b0;
            default:               drop = 1'b0;
        endcase
    end

    assign i_in.ready = rdy;
    assign o_push     = i_in.valid && rdy && !drop;
    assign o_cmd      = cmd;

endmodule

@@ hw/rtl/dwa_queue.sv @@
// Small command FIFO between the front end and the back end.
module dwa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dwa_pkg::t_cmd i_push_data,
    output logic          o_full,
    output logic          o_valid,
    output dwa_pkg::t_cmd o_head,
    input  logic          i_pop
);

    localparam int DEPTH = dwa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dwa_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

@@ hw/rtl/dwa_back.sv @@
// Back end: table stores, clearing sweep, automaton stepping and verdict register.
module dwa_back #(
    parameter int NUM_STATES  = dwa_pkg::NUM_STATES_DEF,
    parameter int SYMBOL_BITS = dwa_pkg::SYMBOL_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dwa_pkg::t_cfg i_cfg,
    input  logic          i_head_valid,
    input  dwa_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_clr_busy,
    dwa_out_if.source     o_out
);

    localparam int STATE_W   = dwa_pkg::STATE_W;
    localparam int ST_IDX_W  = $clog2(NUM_STATES);
    localparam int ALPHA_DEP = 1 << SYMBOL_BITS;
    localparam int TBL_DEP   = NUM_STATES * ALPHA_DEP;
    localparam int TBL_AW    = ST_IDX_W + SYMBOL_BITS;
    localparam int ENTRY_W   = dwa_pkg::ENTRY_W;

    dwa_pkg::t_bk_state r_state, n_state;
    logic [STATE_W-1:0] r_cur, n_cur;
    dwa_pkg::t_outcome  r_fail, n_fail;
    logic               r_mid, n_mid;
    logic               r_last, n_last;
    logic [TBL_AW-1:0]  r_clr_cnt;
    logic               r_clr_done;
    logic               r_out_valid, n_out_valid;
    dwa_pkg::t_verdict  r_out, n_out;

    logic [STATE_W-1:0]          eff_cur;
    dwa_pkg::t_outcome           eff_fail;
    dwa_pkg::t_outcome           hd_fail;
    logic                        out_free;
    logic                        fetch_go;
    logic                        needs_out;
    logic                        fetch_fire;
    logic                        do_lookup;
    logic                        eff_oob;
    logic                        cur_oob;
    logic                        lk_fire;
    dwa_pkg::t_outcome           new_fail;
    logic [STATE_W-1:0]          new_cur;
    logic [STATE_W+ST_IDX_W-1:0] from_ext;
    logic [STATE_W+ST_IDX_W-1:0] cur_ext;
    logic [TBL_AW-1:0]           wr_idx;
    logic [TBL_AW-1:0]           rd_idx;

    logic                   tbl_we;
    logic [TBL_AW-1:0]      tbl_wr_addr;
    logic [ENTRY_W-1:0]     tbl_wr_data;
    logic                   tbl_re;
    logic [ENTRY_W-1:0]     tbl_q;
    logic                   alpha_we;
    logic [SYMBOL_BITS-1:0] alpha_wr_addr;
    logic                   alpha_wr_data;
    logic                   alpha_q;

    assign eff_cur  = r_mid ? r_cur : i_cfg.start_state;
    assign eff_fail = r_mid ? r_fail : dwa_pkg::OUT_ACCEPTED;
    assign hd_fail  = (eff_fail != dwa_pkg::OUT_ACCEPTED) ? eff_fail :
                      (i_head.sym_oob ? dwa_pkg::OUT_NOT_IN_ALPHABET : dwa_pkg::OUT_ACCEPTED);
    assign out_free = !r_out_valid || o_out.ready;

    assign fetch_go  = (r_state == dwa_pkg::BK_FETCH) && i_head_valid && r_clr_done;
    assign needs_out = (i_head.op == dwa_pkg::ACT_EMPTY) ||
                       ((i_head.op == dwa_pkg::ACT_SYMBOL) && i_head.last &&
                        (hd_fail != dwa_pkg::OUT_ACCEPTED));
    assign fetch_fire = fetch_go && (!needs_out || out_free);
    assign do_lookup  = fetch_fire && (i_head.op == dwa_pkg::ACT_SYMBOL) &&
                        (hd_fail == dwa_pkg::OUT_ACCEPTED);

    assign from_ext = {{ST_IDX_W{1'b0}}, i_head.from_state};
    assign cur_ext  = {{ST_IDX_W{1'b0}}, eff_cur};
    assign wr_idx   = {from_ext[ST_IDX_W-1:0], i_head.symbol[SYMBOL_BITS-1:0]};
    assign rd_idx   = {cur_ext[ST_IDX_W-1:0], i_head.symbol[SYMBOL_BITS-1:0]};
    assign eff_oob  = 9'(eff_cur) >= 9'(NUM_STATES);
    assign cur_oob  = 9'(r_cur) >= 9'(NUM_STATES);

    // lookup result: alphabet check wins over a missing transition
    always_comb begin
        if (!alpha_q) begin
            new_fail = dwa_pkg::OUT_NOT_IN_ALPHABET;
        end else if (cur_oob || !tbl_q[ENTRY_W-1]) begin
            new_fail = dwa_pkg::OUT_NO_TRANSITION;
        end else begin
            new_fail = dwa_pkg::OUT_ACCEPTED;
        end
        new_cur = (new_fail == dwa_pkg::OUT_ACCEPTED) ? tbl_q[STATE_W-1:0] : r_cur;
    end

    assign lk_fire = (r_state == dwa_pkg::BK_LOOKUP) && (!r_last || out_free);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dwa_pkg::BK_FETCH: begin
                if (do_lookup) begin
                    n_state = dwa_pkg::BK_LOOKUP;
                end
            end
            dwa_pkg::BK_LOOKUP: begin
                if (lk_fire) begin
                    n_state = dwa_pkg::BK_FETCH;
                end
            end
            default: n_state = dwa_pkg::BK_FETCH;
        endcase
    end

    // outputs and datapath
    always_comb begin
        n_cur         = r_cur;
        n_fail        = r_fail;
        n_mid         = r_mid;
        n_last        = r_last;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !o_out.ready;
        o_pop         = fetch_fire;
        tbl_we        = !r_clr_done;
        tbl_wr_addr   = r_clr_cnt;
        tbl_wr_data   = '0;
        tbl_re        = do_lookup && !eff_oob;
        alpha_we      = !r_clr_done;
        alpha_wr_addr = r_clr_cnt[SYMBOL_BITS-1:0];
        alpha_wr_data = 1'b0;

        unique case (r_state)
            dwa_pkg::BK_FETCH: begin
                if (fetch_fire) begin
                    unique case (i_head.op)
                        dwa_pkg::ACT_WR_TRANS: begin
                            tbl_we      = 1'b1;
                            tbl_wr_addr = wr_idx;
                            tbl_wr_data = {i_head.entry_valid, i_head.to_state};
                        end
                        dwa_pkg::ACT_WR_ALPHA: begin
                            alpha_we      = 1'b1;
                            alpha_wr_addr = i_head.symbol[SYMBOL_BITS-1:0];
                            alpha_wr_data = i_head.entry_valid;
                        end
                        dwa_pkg::ACT_EMPTY: begin
                            n_out       = dwa_pkg::make_verdict(eff_cur, eff_fail,
                                                                i_cfg.accept_mask);
                            n_out_valid = 1'b1;
                            n_fail      = dwa_pkg::OUT_ACCEPTED;
                            n_mid       = 1'b0;
                        end
                        dwa_pkg::ACT_SYMBOL: begin
                            if (hd_fail == dwa_pkg::OUT_ACCEPTED) begin
                                n_cur  = eff_cur;
                                n_fail = dwa_pkg::OUT_ACCEPTED;
                                n_mid  = 1'b1;
                                n_last = i_head.last;
                            end else if (i_head.last) begin
                                n_out       = dwa_pkg::make_verdict(eff_cur, hd_fail,
                                                                    i_cfg.accept_mask);
                                n_out_valid = 1'b1;
                                n_fail      = dwa_pkg::OUT_ACCEPTED;
                                n_mid       = 1'b0;
                            end else begin
                                n_cur  = eff_cur;
                                n_fail = hd_fail;
                                n_mid  = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dwa_pkg::BK_LOOKUP: begin
                if (lk_fire) begin
                    if (r_last) begin
                        n_out       = dwa_pkg::make_verdict(new_cur, new_fail,
                                                            i_cfg.accept_mask);
                        n_out_valid = 1'b1;
                        n_fail      = dwa_pkg::OUT_ACCEPTED;
                        n_mid       = 1'b0;
                    end else begin
                        n_cur  = new_cur;
                        n_fail = new_fail;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dwa_pkg::BK_FETCH;
            r_cur       <= '0;
            r_fail      <= dwa_pkg::OUT_ACCEPTED;
            r_mid       <= 1'b0;
            r_last      <= 1'b0;
            r_clr_cnt   <= '0;
            r_clr_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur       <= n_cur;
            r_fail      <= n_fail;
            r_mid       <= n_mid;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            if (!r_clr_done) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
                if (r_clr_cnt == TBL_AW'(TBL_DEP - 1)) begin
                    r_clr_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    dwa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEP)
    ) u_tbl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_we),
        .i_wr_addr (tbl_wr_addr),
        .i_wr_data (tbl_wr_data),
        .i_rd_en   (tbl_re),
        .i_rd_addr (rd_idx),
        .o_rd_data (tbl_q)
    );

    dwa_ram #(
        .WIDTH (1),
        .DEPTH (ALPHA_DEP)
    ) u_alpha_ram (
        .i_clk     (i_clk),
        .i_wr_en   (alpha_we),
        .i_wr_addr (alpha_wr_addr),
        .i_wr_data (alpha_wr_data),
        .i_rd_en   (do_lookup),
        .i_rd_addr (i_head.symbol[SYMBOL_BITS-1:0]),
        .o_rd_data (alpha_q)
    );

    assign o_clr_busy      = !r_clr_done;
    assign o_out.valid     = r_out_valid;
    assign o_out.accepted  = r_out.accepted;
    assign o_out.outcome   = r_out.outcome;
    assign o_out.end_state = r_out.end_state;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for dfa_word_acceptor: loads automata, feeds words, checks verdicts.
module tb;

    localparam int STATE_W    = dwa_pkg::STATE_W;
    localparam int SYM_W      = dwa_pkg::SYM_W;
    localparam int ENTRY_W    = dwa_pkg::ENTRY_W;
    localparam int ACCEPT_W   = dwa_pkg::ACCEPT_W;
    localparam int CFG_IDX_W  = dwa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = dwa_pkg::CFG_DATA_W;

    localparam int CYCLE_LIMIT   = 200000;  // clear sweep plus ~1600 items at worst pacing, wide margin
    localparam int SETTLE_CYCLES = 32;      // 4-deep queue of symbols, each through fetch and lookup, plus pipe
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_ITEMS   = 400;
    localparam int MAX_PRINTS    = 100;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED3 = 2'd3;

    typedef struct {
        dwa_pkg::t_action   act;
        logic [STATE_W-1:0] from_state;
        logic [SYM_W-1:0]   symbol;
        logic [STATE_W-1:0] to_state;
        logic               entry_valid;
        logic               last_symbol;
    } t_dfa_item;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dwa_in_if  in_if();
    dwa_out_if out_if();
    dwa_cfg_if cfg_if();

    dfa_word_acceptor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #1 i_clk = ~i_clk;

    // automaton shadow
    bit [ENTRY_W-1:0]    trans_tbl [0:(1 << (STATE_W + SYM_W)) - 1];
    bit                  alpha_bits [0:(1 << SYM_W) - 1];
    logic [STATE_W-1:0]  start_reg  = '0;
    logic [ACCEPT_W-1:0] accept_reg = '0;
    logic [STATE_W-1:0]  cur_state  = '0;
    dwa_pkg::t_outcome   fail_code  = dwa_pkg::OUT_ACCEPTED;
    bit                  in_word    = 1'b0;

    t_dfa_item         word_items[$];
    dwa_pkg::t_verdict pending_verdicts[$];

    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    bit  in_taken, cfg_taken;
    bit  hold_req, hold_done;
    int  hold_left;
    int  cycle_cnt;
    int  err_cnt;
    int  verdict_cnt;

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        // keep the log bounded when the block is badly off
        if (err_cnt <= MAX_PRINTS)
            $display("ERROR t=%0t verdict #%0d %s: got %0d expected %0d",
                     $time, verdict_cnt, what, got, want);
    endtask

    function automatic dwa_pkg::t_verdict close_word();
        dwa_pkg::t_verdict v;
        v.end_state = cur_state;
        if (fail_code != dwa_pkg::OUT_ACCEPTED) begin
            v.accepted = 1'b0;
            v.outcome  = fail_code;
        end else if (accept_reg[cur_state]) begin
            v.accepted = 1'b1;
            v.outcome  = dwa_pkg::OUT_ACCEPTED;
        end else begin
            v.accepted = 1'b0;
            v.outcome  = dwa_pkg::OUT_NON_FINAL;
        end
        cur_state = start_reg;
        fail_code = dwa_pkg::OUT_ACCEPTED;
        in_word   = 1'b0;
        return v;
    endfunction

    // returns 1 when the item closes a word
    function automatic bit step_automaton(input t_dfa_item it, output dwa_pkg::t_verdict v);
        bit [ENTRY_W-1:0] ent;
        v = '0;
        case (it.act)
            dwa_pkg::ACT_WR_TRANS: begin
                trans_tbl[{it.from_state, it.symbol}] = {it.entry_valid, it.to_state};
                return 1'b0;
            end
            dwa_pkg::ACT_WR_ALPHA: begin
                alpha_bits[it.symbol] = it.entry_valid;
                return 1'b0;
            end
            dwa_pkg::ACT_EMPTY: begin
                if (!in_word)
                    cur_state = start_reg;
                v = close_word();
                return 1'b1;
            end
            default: ;
        endcase
        if (!in_word) begin
            cur_state = start_reg;
            fail_code = dwa_pkg::OUT_ACCEPTED;
            in_word   = 1'b1;
        end
        if (fail_code == dwa_pkg::OUT_ACCEPTED) begin
            if (!alpha_bits[it.symbol]) begin
                fail_code = dwa_pkg::OUT_NOT_IN_ALPHABET;
            end else begin
                ent = trans_tbl[{cur_state, it.symbol}];
                if (ent[ENTRY_W-1])
                    cur_state = ent[STATE_W-1:0];
                else
                    fail_code = dwa_pkg::OUT_NO_TRANSITION;
            end
        end
        if (it.last_symbol) begin
            v = close_word();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // input driver
    always @(negedge i_clk) begin
        t_dfa_item nxt;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_taken) begin
            if (word_items.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                nxt = word_items.pop_front();
                in_if.valid       <= 1'b1;
                in_if.action      <= nxt.act;
                in_if.from_state  <= nxt.from_state;
                in_if.symbol      <= nxt.symbol;
                in_if.to_state    <= nxt.to_state;
                in_if.entry_valid <= nxt.entry_valid;
                in_if.last_symbol <= nxt.last_symbol;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // verdict receiver, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            out_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= i_rst_n && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // monitor: predicts on each input transfer, checks each verdict transfer
    always @(posedge i_clk) begin
        t_dfa_item         got;
        dwa_pkg::t_verdict res, want;
        cycle_cnt = cycle_cnt + 1;
        in_taken  <= i_rst_n && in_if.valid && in_if.ready;
        cfg_taken <= i_rst_n && cfg_if.valid && cfg_if.ready;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                verdict_cnt++;
                res.accepted  = out_if.accepted;
                res.outcome   = dwa_pkg::t_outcome'(out_if.outcome);
                res.end_state = out_if.end_state;
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("unexpected verdict, end_state", int'(res.end_state), 0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (res.accepted != want.accepted)
                        report_mismatch("accepted", int'(res.accepted), int'(want.accepted));
                    if (res.outcome != want.outcome)
                        report_mismatch("outcome", int'(res.outcome), int'(want.outcome));
                    if (res.end_state != want.end_state)
                        report_mismatch("end_state", int'(res.end_state),
                                        int'(want.end_state));
                end
            end
            if (in_if.valid && in_if.ready) begin
                got.act         = dwa_pkg::t_action'(in_if.action);
                got.from_state  = in_if.from_state;
                got.symbol      = in_if.symbol;
                got.to_state    = in_if.to_state;
                got.entry_valid = in_if.entry_valid;
                got.last_symbol = in_if.last_symbol;
                if (step_automaton(got, want))
                    pending_verdicts.insert(pending_verdicts.size(), want);
            end
            if (cfg_if.valid && cfg_if.ready) begin
                if (cfg_if.index == dwa_pkg::CFG_START_STATE)
                    start_reg = cfg_if.data[STATE_W-1:0];
                else if (cfg_if.index == dwa_pkg::CFG_ACCEPT_MASK)
                    accept_reg = cfg_if.data;
            end
        end
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("FAIL dfa_word_acceptor");
        $finish;
    end

    task automatic add_item(input dwa_pkg::t_action a, input logic [STATE_W-1:0] fs,
                            input logic [SYM_W-1:0] sym, input logic [STATE_W-1:0] ts,
                            input bit ev, input bit last);
        t_dfa_item it;
        it.act         = a;
        it.from_state  = fs;
        it.symbol      = sym;
        it.to_state    = ts;
        it.entry_valid = ev;
        it.last_symbol = last;
        word_items.insert(word_items.size(), it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(negedge i_clk); while (!cfg_taken);
        cfg_if.valid <= 1'b0;
    endtask

    // everything sent and answered, then let trailing loads drain
    task automatic wait_idle();
        do @(negedge i_clk);
        while (word_items.size() != 0 || in_if.valid || pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // random automaton over a small pool of states and symbols, then words that walk it
    task automatic fill_random(input int n, input logic [STATE_W-1:0] first_state);
        logic [STATE_W-1:0] st_pool [6];
        logic [SYM_W-1:0]   sym_pool [5];
        logic [SYM_W-1:0]   s;
        int cnt, len, r, term;
        cnt = 0;
        st_pool[0] = first_state;
        for (int i = 1; i < 6; i++)
            st_pool[i] = STATE_W'($urandom_range(63));
        for (int j = 0; j < 5; j++) begin
            sym_pool[j] = SYM_W'($urandom_range(255));
            add_item(dwa_pkg::ACT_WR_ALPHA, STATE_W'($urandom), sym_pool[j],
                     STATE_W'($urandom), 1'b1, 1'($urandom_range(1)));
            cnt++;
        end
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 5; j++) begin
                add_item(dwa_pkg::ACT_WR_TRANS, st_pool[i], sym_pool[j],
                         st_pool[$urandom_range(5)], $urandom_range(9) != 0,
                         1'($urandom_range(1)));
                cnt++;
            end
        end
        while (cnt < n) begin
            r = $urandom_range(99);
            if (r < 5) begin
                if ($urandom_range(1))
                    add_item(dwa_pkg::ACT_WR_TRANS,
                             $urandom_range(1) ? st_pool[$urandom_range(5)] : STATE_W'($urandom),
                             $urandom_range(1) ? sym_pool[$urandom_range(4)] : SYM_W'($urandom),
                             $urandom_range(1) ? st_pool[$urandom_range(5)] : STATE_W'($urandom),
                             $urandom_range(3) != 0, 1'($urandom_range(1)));
                else
                    add_item(dwa_pkg::ACT_WR_ALPHA, STATE_W'($urandom),
                             $urandom_range(1) ? sym_pool[$urandom_range(4)] : SYM_W'($urandom),
                             STATE_W'($urandom), $urandom_range(3) != 0,
                             1'($urandom_range(1)));
                cnt++;
            end else if (r < 10) begin
                add_item(dwa_pkg::ACT_EMPTY, STATE_W'($urandom), SYM_W'($urandom),
                         STATE_W'($urandom), 1'($urandom_range(1)), 1'($urandom_range(1)));
                cnt++;
            end else begin
                len  = $urandom_range(6, 1);
                term = $urandom_range(9);
                for (int k = 0; k < len; k++) begin
                    s = ($urandom_range(9) != 0) ? sym_pool[$urandom_range(4)] : SYM_W'($urandom);
                    add_item(dwa_pkg::ACT_SYMBOL, STATE_W'($urandom), s, STATE_W'($urandom),
                             1'($urandom_range(1)), (k == len - 1) && term > 1);
                    cnt++;
                    // occasional load in the middle of a word
                    if (k != len - 1 && $urandom_range(99) < 3) begin
                        add_item(dwa_pkg::ACT_WR_TRANS, st_pool[$urandom_range(5)],
                                 sym_pool[$urandom_range(4)], st_pool[$urandom_range(5)],
                                 1'($urandom_range(1)), 1'($urandom_range(1)));
                        cnt++;
                    end
                end
                // term 1: word runs on into the next one
                if (term == 0) begin
                    add_item(dwa_pkg::ACT_EMPTY, STATE_W'($urandom), SYM_W'($urandom),
                             STATE_W'($urandom), 1'($urandom_range(1)), 1'b0);
                    cnt++;
                end
            end
        end
        // close any open word before the next register write
        add_item(dwa_pkg::ACT_EMPTY, '0, '0, '0, 1'b0, 1'b0);
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct,
                             input logic [STATE_W-1:0] st, input logic [ACCEPT_W-1:0] mask,
                             input bit press);
        write_reg(dwa_pkg::CFG_START_STATE, {{(CFG_DATA_W-STATE_W){1'b0}}, st});
        write_reg(dwa_pkg::CFG_ACCEPT_MASK, mask);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        if (press)
            hold_req = 1'b1;
        fill_random(PHASE_ITEMS, st);
        wait_idle();
    endtask

    initial begin
        cfg_if.valid = 1'b0;
        cfg_if.index = dwa_pkg::CFG_START_STATE;
        cfg_if.data  = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register writes are taken during the clear sweep
        write_reg(dwa_pkg::CFG_START_STATE, 64'd63);
        write_reg(dwa_pkg::CFG_ACCEPT_MASK, 64'h8000_0000_0000_0002);
        write_reg(CFG_UNUSED2, {$urandom, $urandom});
        write_reg(CFG_UNUSED3, {$urandom, $urandom});

        // directed: empty word while idle
        add_item(dwa_pkg::ACT_EMPTY, 6'h3F, 8'hFF, 6'h3F, 1'b1, 1'b1);
        // alphabet 0x00 and 0xFF; 0x41 set then cleared
        add_item(dwa_pkg::ACT_WR_ALPHA, 6'h00, 8'hFF, 6'h00, 1'b1, 1'b0);
        add_item(dwa_pkg::ACT_WR_ALPHA, 6'h3F, 8'h00, 6'h3F, 1'b1, 1'b1);
        add_item(dwa_pkg::ACT_WR_ALPHA, 6'h15, 8'h41, 6'h2A, 1'b1, 1'b0);
        add_item(dwa_pkg::ACT_WR_ALPHA, 6'h2A, 8'h41, 6'h15, 1'b0, 1'b0);
        add_item(dwa_pkg::ACT_WR_TRANS, 6'h3F, 8'hFF, 6'h00, 1'b1, 1'b0);
        add_item(dwa_pkg::ACT_WR_TRANS, 6'h00, 8'h00, 6'h3F, 1'b1, 1'b0);
        add_item(dwa_pkg::ACT_WR_TRANS, 6'h3F, 8'h00, 6'h2A, 1'b0, 1'b0);
        // two-symbol word back to the accepting start
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'hFF, 6'h00, 1'b0, 1'b0);
        add_item(dwa_pkg::ACT_SYMBOL, 6'h3F, 8'h00, 6'h3F, 1'b1, 1'b1);
        // symbol outside alphabet, rest of the word ignored
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'h41, 6'h00, 1'b0, 1'b0);
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'hFF, 6'h00, 1'b0, 1'b0);
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'h00, 6'h00, 1'b0, 1'b1);
        // missing transition on the last symbol
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'h00, 6'h00, 1'b0, 1'b1);
        // empty-word action closes a word in progress
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'hFF, 6'h00, 1'b0, 1'b0);
        add_item(dwa_pkg::ACT_EMPTY, 6'h00, 8'h00, 6'h00, 1'b0, 1'b0);
        // overwrite an entry, then load in the middle of a word (last flag ignored)
        add_item(dwa_pkg::ACT_WR_TRANS, 6'h3F, 8'hFF, 6'h01, 1'b1, 1'b0);
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'hFF, 6'h00, 1'b0, 1'b0);
        add_item(dwa_pkg::ACT_WR_TRANS, 6'h01, 8'h00, 6'h3E, 1'b1, 1'b1);
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'h00, 6'h00, 1'b0, 1'b1);
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'hFF, 6'h00, 1'b0, 1'b1);
        add_item(dwa_pkg::ACT_SYMBOL, 6'h00, 8'h41, 6'h00, 1'b0, 1'b1);
        wait_idle();

        run_phase(0, 0, 6'd0, {ACCEPT_W{1'b1}}, 1'b1);
        run_phase(67, 0, 6'd63, '0, 1'b0);
        run_phase(0, 67, STATE_W'($urandom_range(63)), {$urandom, $urandom}, 1'b0);
        run_phase(33, 33, STATE_W'($urandom_range(63)), {$urandom, $urandom}, 1'b0);

        if (err_cnt == 0)
            $display("PASS dfa_word_acceptor");
        else
            $display("FAIL dfa_word_acceptor");
        $finish;
    end

endmodule
